/* rtl/assert_macros.svh */
// Assertion helpers, clocked on clk and disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication.
`define ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

/* rtl/vfrp_pkg.sv */
package vfrp_pkg;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_INVALID     = 3'd1,
    ST_NULL        = 3'd2,
    ST_MONITOR_ERR = 3'd3,
    ST_OVERFLOW    = 3'd4
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  value_type;
    logic [14:0] max_value;
    logic [14:0] cur_value;
  } result_t;

  localparam logic [7:0] LEN_MARK    = 8'h80;
  localparam logic [7:0] SENDER_ADDR = 8'h6E;
  localparam logic [7:0] REPLY_CMD   = 8'h02;
  localparam logic [7:0] RESULT_ERR  = 8'h01;
  localparam logic [7:0] PAYLOAD_LEN = 8'd7;

  // Byte positions within a reply frame.
  localparam logic [3:0] POS_SENDER = 4'd0;
  localparam logic [3:0] POS_LENGTH = 4'd1;
  localparam logic [3:0] POS_CMD    = 4'd2;
  localparam logic [3:0] POS_RESULT = 4'd3;
  localparam logic [3:0] POS_OPCODE = 4'd4;
  localparam logic [3:0] POS_TYPE   = 4'd5;
  localparam logic [3:0] POS_MAX_HI = 4'd6;
  localparam logic [3:0] POS_MAX_LO = 4'd7;
  localparam logic [3:0] POS_CUR_HI = 4'd8;
  localparam logic [3:0] POS_CUR_LO = 4'd9;

endpackage

/* rtl/vfrp_parser.sv */
module vfrp_parser
  import vfrp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic       start_req,
  input  logic [7:0] data_byte,
  input  logic [7:0] feature,
  output logic       res_valid,
  output result_t    res
);

  logic [3:0]  pos_r, pos_nxt;
  logic        wait_r, wait_nxt;
  logic        sender_ok_r, sender_ok_nxt;
  logic [7:0]  req_r, req_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [15:0] maxw_r, maxw_nxt;
  logic [7:0]  curh_r, curh_nxt;

  logic       active;
  logic [3:0] pos;
  logic       done;

  assign active = accept && (start_req || !wait_r);
  assign pos    = start_req ? POS_SENDER : pos_r;

  always_comb begin
    pos_nxt       = pos_r;
    wait_nxt      = wait_r;
    sender_ok_nxt = sender_ok_r;
    req_nxt       = req_r;
    type_nxt      = type_r;
    maxw_nxt      = maxw_r;
    curh_nxt      = curh_r;
    done          = 1'b0;
    res           = '{status: ST_OK, value_type: 8'd0, max_value: 15'd0, cur_value: 15'd0};

    if (accept && start_req) begin
      req_nxt       = feature;
      wait_nxt      = 1'b0;
      sender_ok_nxt = 1'b0;
    end

    if (active) begin
      pos_nxt = pos + 4'd1;
      unique case (pos)
        POS_SENDER: begin
          sender_ok_nxt = (data_byte == SENDER_ADDR);
          if (data_byte != SENDER_ADDR) begin
            done = 1'b1;
            res.status = ST_INVALID;
          end
        end
        POS_LENGTH: begin
          done = 1'b1;
          if (!sender_ok_r || !data_byte[7]) res.status = ST_INVALID;
          else if (data_byte == LEN_MARK) res.status = ST_NULL;
          else if (data_byte != (LEN_MARK | (PAYLOAD_LEN + 8'd1))) res.status = ST_INVALID;
          else done = 1'b0;
        end
        POS_CMD: begin
          if (data_byte != REPLY_CMD) begin
            done = 1'b1;
            res.status = ST_INVALID;
          end
        end
        POS_RESULT: begin
          if (data_byte == RESULT_ERR) begin
            done = 1'b1;
            res.status = ST_MONITOR_ERR;
          end else if (data_byte != 8'd0) begin
            done = 1'b1;
            res.status = ST_INVALID;
          end
        end
        POS_OPCODE: begin
          if (data_byte != req_nxt) begin
            done = 1'b1;
            res.status = ST_INVALID;
          end
        end
        POS_TYPE: type_nxt = data_byte;
        POS_MAX_HI: begin
          maxw_nxt = {data_byte, 8'd0};
          if (data_byte[7]) begin
            done = 1'b1;
            res.status = ST_OVERFLOW;
          end
        end
        POS_MAX_LO: maxw_nxt = {maxw_r[15:8], data_byte};
        POS_CUR_HI: begin
          curh_nxt = data_byte;
          if (data_byte[7]) begin
            done = 1'b1;
            res.status = ST_OVERFLOW;
          end
        end
        POS_CUR_LO: begin
          done = 1'b1;
          res = '{status: ST_OK, value_type: type_r, max_value: maxw_r[14:0],
                  cur_value: {curh_r[6:0], data_byte}};
        end
        default: wait_nxt = 1'b1;
      endcase
      if (done) wait_nxt = 1'b1;
    end
  end

  assign res_valid = done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= 4'd0;
      wait_r      <= 1'b1;
      sender_ok_r <= 1'b0;
      req_r       <= 8'd0;
    end else begin
      pos_r       <= pos_nxt;
      wait_r      <= wait_nxt;
      sender_ok_r <= sender_ok_nxt;
      req_r       <= req_nxt;
    end
  end

  always_ff @(posedge clk) begin
    type_r <= type_nxt;
    maxw_r <= maxw_nxt;
    curh_r <= curh_nxt;
  end

endmodule

/* rtl/vcp_feature_reply_parser_top.sv */
// Channel | Direction | Payload
// in_     | input     | start_req, data_byte, feature
// out_    | output    | status, value_type, max_value, cur_value
//
// One byte per cycle unless in_stall; a status is registered into out_r, or into the skid while out_ stalls.
// The parser state and the output register are the only pipeline: no other stage.
// A two-entry output buffer (register plus skid) absorbs out_stall; in_stall is
// the registered skid-full flag, so input transfers continue while one result waits.
// rst_n is synchronous: the parser ignores bytes until the next start_req.
module vcp_feature_reply_parser_top
  import vfrp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_start_req,
  input  logic [7:0]  in_data_byte,
  input  logic [7:0]  in_feature,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [7:0]  out_value_type,
  output logic [14:0] out_max_value,
  output logic [14:0] out_cur_value
);
`include "assert_macros.svh"

  logic    accept;
  logic    res_valid;
  result_t res;
  logic    out_valid_r, skid_valid_r;
  result_t out_r, skid_r;
  logic    out_take;

  assign in_stall = skid_valid_r;
  assign accept   = in_valid && !in_stall;
  assign out_take = out_valid_r && !out_stall;

  vfrp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .start_req (in_start_req),
    .data_byte (in_data_byte),
    .feature   (in_feature),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (skid_valid_r && out_take) begin
        out_r        <= skid_r;
        skid_valid_r <= 1'b0;
      end else if (res_valid) begin
        if (!out_valid_r || out_take) begin
          out_r       <= res;
          out_valid_r <= 1'b1;
        end else begin
          skid_r       <= res;
          skid_valid_r <= 1'b1;
        end
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_r.status;
  assign out_value_type = out_r.value_type;
  assign out_max_value  = out_r.max_value;
  assign out_cur_value  = out_r.cur_value;

  `ASSERT_IMP(a_skid_implies_out, skid_valid_r, out_valid_r)
  `ASSERT_NXT(a_result_held, out_valid_r && out_stall, out_valid_r)
  `ASSERT_IMP(a_err_zero_payload, out_valid_r && (out_r.status != ST_OK),
              (out_r.value_type == 8'd0) && (out_r.max_value == 15'd0) &&
              (out_r.cur_value == 15'd0))
  `ASSERT_IMP(a_no_accept_when_full, skid_valid_r, !accept)

endmodule
